FILE: hdl/clsr_pkg.sv
// ============================================================================
// clsr_pkg
// Shared constants and command types for the combined LCG shuffle generator.
// ============================================================================
package clsr_pkg;

    // Operation codes carried by the op field.
    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_SEED = 1'b1;

    // Generator moduli and multipliers.
    localparam logic [30:0] MOD1 = 31'd2147483563;
    localparam logic [30:0] MOD2 = 31'd2147483399;
    localparam logic [15:0] MUL1 = 16'd40014;
    localparam logic [15:0] MUL2 = 16'd40692;

    // 2^31 mod each modulus, used to fold the high part of a product.
    localparam logic [7:0] FOLD1 = 8'd85;
    localparam logic [7:0] FOLD2 = 8'd249;

    localparam logic [30:0] SEED2_RESET = 31'd123456789;
    localparam logic [30:0] SPAN        = 31'd2147483562;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_seed;  // capture the seed into the first generator
        logic warm_init;  // load the seed magnitude into both generators
        logic step1;      // advance the first generator
        logic step2;      // advance the second generator
        logic warm_wr;    // write the stepped first generator into the table
        logic warm_last;  // last warm-up step: also set the last output
        logic draw_done;  // finish a draw: swap table entry, load result
    } t_dp_cmd;

endpackage

FILE: hdl/clsr_ctrl.sv
// ============================================================================
// clsr_ctrl
// Sequencer for seed loads, the warm-up loop and the draw.
// ============================================================================
module clsr_ctrl #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_op,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    input  logic                           i_first_nonpos,
    output clsr_pkg::t_dp_cmd              o_cmd,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_wr_idx
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 8);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WLOAD,
        S_WMUL,
        S_WRED,
        S_DMUL,
        S_DRED,
        S_DREAD,
        S_DOUT
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_out_valid;
    logic               in_accept;
    logic               out_free;

    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_wr_idx    = r_cnt[IDX_W-1:0];

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_seed = in_accept && (i_op == clsr_pkg::OP_SEED);
            end
            S_WLOAD: begin
                o_cmd.warm_init = 1'b1;
            end
            S_WRED: begin
                o_cmd.step1     = 1'b1;
                o_cmd.warm_wr   = (r_cnt < CNT_W'(TABLE_DEPTH));
                o_cmd.warm_last = (r_cnt == '0);
            end
            S_DRED: begin
                o_cmd.step1 = 1'b1;
                o_cmd.step2 = 1'b1;
            end
            S_DOUT: begin
                o_cmd.draw_done = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept && (i_op == clsr_pkg::OP_DRAW)) begin
                        // Products for the draw are already captured at this edge.
                        r_state <= i_first_nonpos ? S_WLOAD : S_DRED;
                    end
                end
                S_WLOAD: begin
                    r_cnt   <= CNT_W'(TABLE_DEPTH + 7);
                    r_state <= S_WMUL;
                end
                S_WMUL: begin
                    r_state <= S_WRED;
                end
                S_WRED: begin
                    if (r_cnt == '0) begin
                        r_state <= S_DMUL;
                    end else begin
                        r_cnt   <= r_cnt - CNT_W'(1);
                        r_state <= S_WMUL;
                    end
                end
                S_DMUL: begin
                    r_state <= S_DRED;
                end
                S_DRED: begin
                    r_state <= S_DREAD;
                end
                S_DREAD: begin
                    r_state <= S_DOUT;
                end
                S_DOUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hdl/clsr_datapath.sv
// ============================================================================
// clsr_datapath
// Generator registers, modular multiply units, slot divider and shuffle table.
// ============================================================================
module clsr_datapath #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  clsr_pkg::t_dp_cmd              i_cmd,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_wr_idx,
    input  logic signed [31:0]             i_seed_value,
    output logic                           o_first_nonpos,
    output logic [30:0]                    o_random_value
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int SW    = $clog2(TABLE_DEPTH) + 1;
    localparam int PW    = 31 + SW;
    // Slot divisor and a reciprocal that is at most one low.
    localparam longint SLOT_DIV   = 64'sd1 + longint'(clsr_pkg::SPAN) / TABLE_DEPTH;
    localparam longint SLOT_RECIP = (64'sd1 <<< 31) / SLOT_DIV;

    logic signed [31:0] r_first_gen;
    logic [30:0]        r_second_gen;
    logic [30:0]        r_last;
    logic [46:0]        r_p1;
    logic [46:0]        r_p2;
    logic [SW-1:0]      r_est;
    logic [IDX_W-1:0]   r_slot;
    logic [30:0]        r_rdata;
    logic               r_rd_valid;
    logic [30:0]        r_out_data;
    logic [30:0]        r_mem [TABLE_DEPTH];
    logic               r_valid [TABLE_DEPTH];

    logic [30:0]        red1;
    logic [30:0]        red2;
    logic [30:0]        mag;
    logic [PW-1:0]      est_prod;
    logic [31:0]        slot_rem;
    logic [SW:0]        slot_q;
    logic [IDX_W-1:0]   n_slot;
    logic [30:0]        tbl_val;
    logic signed [32:0] diff;
    logic [30:0]        n_last;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [30:0]        wr_data;

    // Reduces a 47-bit product modulo (2^31 - fold); the folded sum stays
    // below twice the modulus, so one conditional subtract finishes it.
    function automatic logic [30:0] mod_fold(input logic [46:0] p,
                                             input logic [7:0]  fold,
                                             input logic [30:0] m);
        logic [31:0] x;
        x = {1'b0, p[30:0]} + (32'(p[46:31]) * 32'(fold));
        if (x >= {1'b0, m}) begin
            x = x - {1'b0, m};
        end
        return x[30:0];
    endfunction

    assign red1 = mod_fold(r_p1, clsr_pkg::FOLD1, clsr_pkg::MOD1);
    assign red2 = mod_fold(r_p2, clsr_pkg::FOLD2, clsr_pkg::MOD2);

    assign o_first_nonpos = (r_first_gen <= 32'sd0);
    assign o_random_value = r_out_data;

    // Seed magnitude, at least one and saturated at the top of 31 bits.
    always_comb begin
        if (r_first_gen == 32'sd0) begin
            mag = 31'd1;
        end else if (r_first_gen == 32'sh8000_0000) begin
            mag = 31'h7FFF_FFFF;
        end else begin
            mag = 31'(-r_first_gen);
        end
    end

    // Slot search: the reciprocal estimate is corrected by one compare.
    assign est_prod = PW'(r_last) * PW'(SLOT_RECIP);
    always_comb begin
        slot_rem = {1'b0, r_last} - 32'(32'(r_est) * 32'(SLOT_DIV));
        slot_q   = {1'b0, r_est};
        if (slot_rem >= 32'(SLOT_DIV)) begin
            slot_q = slot_q + (SW+1)'(1);
        end
        if (slot_q > (SW+1)'(TABLE_DEPTH - 1)) begin
            n_slot = IDX_W'(TABLE_DEPTH - 1);
        end else begin
            n_slot = slot_q[IDX_W-1:0];
        end
    end

    always_comb begin
        tbl_val = r_rd_valid ? r_rdata : '0;
        diff    = $signed({2'b00, tbl_val}) - $signed({2'b00, r_second_gen});
        if (diff < 33'sd1) begin
            diff = diff + $signed({2'b00, clsr_pkg::SPAN});
        end
        n_last = diff[30:0];
    end

    assign wr_en   = i_cmd.warm_wr || i_cmd.draw_done;
    assign wr_addr = i_cmd.draw_done ? r_slot : i_wr_idx;
    assign wr_data = i_cmd.draw_done ? r_first_gen[30:0] : red1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_gen  <= '0;
            r_second_gen <= clsr_pkg::SEED2_RESET;
            r_last       <= '0;
        end else begin
            if (i_cmd.load_seed) begin
                r_first_gen <= i_seed_value;
            end else if (i_cmd.warm_init) begin
                r_first_gen <= $signed({1'b0, mag});
            end else if (i_cmd.step1) begin
                r_first_gen <= $signed({1'b0, red1});
            end
            if (i_cmd.warm_init) begin
                r_second_gen <= mag;
            end else if (i_cmd.step2) begin
                r_second_gen <= red2;
            end
            if (i_cmd.warm_last) begin
                r_last <= red1;
            end else if (i_cmd.draw_done) begin
                r_last <= n_last;
            end
        end
    end

    // Products and slot stages run every cycle; the controller picks when
    // their results are used.
    always_ff @(posedge i_clk) begin
        r_p1   <= 47'(clsr_pkg::MUL1) * 47'(r_first_gen[30:0]);
        r_p2   <= 47'(clsr_pkg::MUL2) * 47'(r_second_gen);
        r_est  <= est_prod[PW-1:31];
        r_slot <= n_slot;
        if (i_cmd.draw_done) begin
            r_out_data <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata    <= r_mem[r_slot];
        r_rd_valid <= r_valid[r_slot];
    end

    // An entry never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (wr_en) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

endmodule

FILE: hdl/combined_lcg_shuffle_rng.sv
// ============================================================================
// combined_lcg_shuffle_rng
// Two combined multiplicative congruential generators behind a shuffle table.
// ============================================================================
// A draw or seed is accepted only while idle; a draw passes S_DRED, S_DREAD
// and S_DOUT, which waits out an output stall, into the output register.
// A seed load gives no result. A draw that finds a nonpositive first
// generator first runs the warm-up, which steps it TABLE_DEPTH + 8 times.
// Reset is synchronous, active low; table entries read as zero until written.
module combined_lcg_shuffle_rng #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic signed [31:0] i_seed_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [30:0]        o_random_value
);

    clsr_pkg::t_dp_cmd              cmd;
    logic [$clog2(TABLE_DEPTH)-1:0] wr_idx;
    logic                           first_nonpos;

    clsr_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .i_first_nonpos (first_nonpos),
        .o_cmd          (cmd),
        .o_wr_idx       (wr_idx)
    );

    clsr_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_wr_idx       (wr_idx),
        .i_seed_value   (i_seed_value),
        .o_first_nonpos (first_nonpos),
        .o_random_value (o_random_value)
    );

endmodule
